@@ rtl/core/tomasulo_rob_scheduler_core_assert.svh @@
// Assertion macros for the scheduler core checker
`ifndef TOMASULO_ROB_SCHEDULER_CORE_ASSERT_SVH
`define TOMASULO_ROB_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication
`define TRS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler core check failed");

// next-cycle implication
`define TRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler core check failed");

`endif

@@ rtl/core/trs_pkg.sv @@
package trs_pkg;

    localparam int NUM_REGS_DEF     = 8;
    localparam int ADD_STATIONS_DEF = 3;
    localparam int MUL_STATIONS_DEF = 2;
    localparam int ROB_DEPTH_DEF    = 16;
    localparam int VALUE_WIDTH_DEF  = 32;

    localparam int NUM_RESET_REGS = 6;
    localparam logic signed [63:0] RESET_REGS [NUM_RESET_REGS] = '{
        64'sd0, 64'sd0, 64'sd131072, 64'sd262144, 64'sd393216, 64'sd524288
    };

    localparam logic [7:0] ADD_LAT_DEF = 8'd2;
    localparam logic [7:0] SUB_LAT_DEF = 8'd2;
    localparam logic [7:0] MUL_LAT_DEF = 8'd10;
    localparam logic [7:0] DIV_LAT_DEF = 8'd40;

    localparam logic [2:0] CFG_ADD_LAT = 3'd0;
    localparam logic [2:0] CFG_SUB_LAT = 3'd1;
    localparam logic [2:0] CFG_MUL_LAT = 3'd2;
    localparam logic [2:0] CFG_DIV_LAT = 3'd3;

    localparam logic [1:0] LAT_ADD = 2'd0;
    localparam logic [1:0] LAT_SUB = 2'd1;
    localparam logic [1:0] LAT_MUL = 2'd2;
    localparam logic [1:0] LAT_DIV = 2'd3;

    localparam int U_ADD = 0;
    localparam int U_MUL = 1;

    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    typedef enum logic [1:0] {
        MDU_IDLE,
        MDU_RUN,
        MDU_FIX,
        MDU_DONE
    } t_mdu_state;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  dest_reg;
        logic        src1_is_imm;
        logic [2:0]  src1_reg;
        logic [31:0] src1_imm;
        logic        src2_is_imm;
        logic [2:0]  src2_reg;
        logic [31:0] src2_imm;
    } t_item;

endpackage

@@ rtl/core/trs_queue.sv @@
module trs_queue
    import trs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item      r_data [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_data[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

@@ rtl/core/trs_mdu.sv @@
module trs_mdu
    import trs_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_div,
    input  logic [VALUE_WIDTH-1:0] i_a,
    input  logic [VALUE_WIDTH-1:0] i_b,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_res
);

    localparam int W   = VALUE_WIDTH;
    localparam int NW  = W + 16;
    localparam int MW  = 2 * W;
    localparam int CNW = $clog2(NW + 1);
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    t_mdu_state     r_state, n_state;
    logic           r_div;
    logic           r_neg;
    logic [W-1:0]   r_ma;
    logic [W:0]     r_hi;
    logic [NW-1:0]  r_lo;
    logic [CNW-1:0] r_cnt;
    logic [W-1:0]   r_res;

    logic [W-1:0]   mag_a, mag_b;
    logic           zero_div;
    logic [W:0]     rem2, mul_sum;
    logic           q_bit;
    logic [MW-1:0]  mag_m;
    logic [W-1:0]   fix_res;

    assign mag_a    = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign mag_b    = i_b[W-1] ? (~i_b + 1'b1) : i_b;
    assign zero_div = i_div && (i_b == '0);

    assign rem2    = {r_hi[W-1:0], r_lo[NW-1]};
    assign q_bit   = (rem2 >= {1'b0, r_ma});
    assign mul_sum = r_hi + (r_lo[0] ? {1'b0, r_ma} : '0);

    always_comb begin
        if (r_div) begin
            mag_m = MW'(r_lo);
        end else begin
            mag_m = MW'({r_hi[W-1:0], r_lo[W-1:0]} >> 16);
        end
        if (mag_m > MW'(VMAX)) begin
            fix_res = r_neg ? VMIN : VMAX;
        end else if (r_neg) begin
            fix_res = ~mag_m[W-1:0] + 1'b1;
        end else begin
            fix_res = mag_m[W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MDU_IDLE, MDU_DONE: begin
                if (i_start) begin
                    n_state = zero_div ? MDU_DONE : MDU_RUN;
                end
            end
            MDU_RUN: begin
                if (r_cnt == CNW'(1)) begin
                    n_state = MDU_FIX;
                end
            end
            MDU_FIX: n_state = MDU_DONE;
            default: n_state = MDU_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == MDU_DONE);
        o_res  = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MDU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_div;
            r_neg <= i_a[W-1] ^ i_b[W-1];
            r_hi  <= '0;
            if (i_div) begin
                r_ma  <= mag_b;
                r_lo  <= {mag_a, 16'b0};
                r_cnt <= CNW'(NW);
            end else begin
                r_ma  <= mag_a;
                r_lo  <= NW'(mag_b);
                r_cnt <= CNW'(W);
            end
            if (zero_div) begin
                if (i_a == '0) begin
                    r_res <= '0;
                end else begin
                    r_res <= i_a[W-1] ? VMIN : VMAX;
                end
            end
        end else if (r_state == MDU_RUN) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_div) begin
                r_hi <= q_bit ? (rem2 - {1'b0, r_ma}) : rem2;
                r_lo <= {r_lo[NW-2:0], q_bit};
            end else begin
                r_hi          <= {1'b0, mul_sum[W:1]};
                r_lo[W-1:0]   <= {mul_sum[0], r_lo[W-1:1]};
            end
        end else if (r_state == MDU_FIX) begin
            r_res <= fix_res;
        end
    end

endmodule

@@ rtl/core/tomasulo_rob_scheduler_core.sv @@
// Each item is one scheduler tick; its result item is registered at the edge that pops the
// tick from the two-entry input queue; one item per cycle unless the output stall holds it.
// A tick whose mul/div writeback is due also waits for the iterative mul/div unit to finish.
// Reset is synchronous, active low: clears queue, stations, rename, pointers and units,
// loads register file and latencies; no clearing pass.
module tomasulo_rob_scheduler_core
    import trs_pkg::*;
#(
    parameter int NUM_REGS     = NUM_REGS_DEF,
    parameter int ADD_STATIONS = ADD_STATIONS_DEF,
    parameter int MUL_STATIONS = MUL_STATIONS_DEF,
    parameter int ROB_DEPTH    = ROB_DEPTH_DEF,
    parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_op,
    input  logic [2:0]         i_dest_reg,
    input  logic               i_src1_is_imm,
    input  logic [2:0]         i_src1_reg,
    input  logic signed [31:0] i_src1_imm,
    input  logic               i_src2_is_imm,
    input  logic [2:0]         i_src2_reg,
    input  logic signed [31:0] i_src2_imm,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_issued,
    output logic               o_commit_valid,
    output logic [3:0]         o_commit_tag,
    output logic [2:0]         o_commit_reg,
    output logic signed [31:0] o_commit_value,
    output logic               o_idle,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_wdata
);

    localparam int W  = VALUE_WIDTH;
    localparam int RW = $clog2(NUM_REGS);
    localparam int TW = $clog2(ROB_DEPTH);
    localparam int CW = $clog2(ROB_DEPTH + 1);
    localparam int NS = ADD_STATIONS + MUL_STATIONS;
    localparam int SW = (NS > 1) ? $clog2(NS) : 1;
    localparam logic [63:0] VMAX64 = 64'h7FFF_FFFF_FFFF_FFFF >> (64 - W);

    function automatic logic [W-1:0] sat_w(input logic signed [63:0] x);
        logic signed [63:0] mx;
        logic signed [63:0] mn;
        mx = signed'(VMAX64);
        mn = ~mx;
        if (x > mx) begin
            return mx[W-1:0];
        end else if (x < mn) begin
            return mn[W-1:0];
        end
        return x[W-1:0];
    endfunction

    function automatic logic [RW-1:0] reg_idx(input logic [2:0] f);
        logic [3:0] r;
        r = {1'b0, f};
        for (int j = 0; j < 4; j++) begin
            if (int'(r) >= NUM_REGS) begin
                r = r - 4'(NUM_REGS);
            end
        end
        return RW'(r);
    endfunction

    function automatic logic [W-1:0] addsub(input logic [W-1:0] a, input logic [W-1:0] b,
                                            input logic sub);
        logic [W:0] s;
        s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
        if (s[W] != s[W-1]) begin
            return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        return s[W-1:0];
    endfunction

    // queue
    t_item q_in, q_item;
    logic  q_full, q_valid, tick_fire;

    // architectural state
    logic [W-1:0]  r_rf      [NUM_REGS], n_rf      [NUM_REGS];
    logic          r_rn_v    [NUM_REGS], n_rn_v    [NUM_REGS];
    logic [TW-1:0] r_rn_tag  [NUM_REGS], n_rn_tag  [NUM_REGS];
    logic          r_rn_done [NUM_REGS], n_rn_done [NUM_REGS];
    logic [W-1:0]  r_rn_val  [NUM_REGS], n_rn_val  [NUM_REGS];

    logic          r_st_busy [NS], n_st_busy [NS];
    logic          r_st_kind [NS], n_st_kind [NS];
    logic          r_st_rdy  [NS][2], n_st_rdy  [NS][2];
    logic [TW-1:0] r_st_tag  [NS][2], n_st_tag  [NS][2];
    logic [W-1:0]  r_st_val  [NS][2], n_st_val  [NS][2];
    logic [TW-1:0] r_st_slot [NS], n_st_slot [NS];

    logic          r_rob_done [ROB_DEPTH], n_rob_done [ROB_DEPTH];
    logic [RW-1:0] r_rob_reg  [ROB_DEPTH], n_rob_reg  [ROB_DEPTH];
    logic [W-1:0]  r_rob_val  [ROB_DEPTH], n_rob_val  [ROB_DEPTH];

    logic [TW-1:0] r_head, n_head, r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    logic          r_u_busy [2], n_u_busy [2];
    logic [8:0]    r_u_cnt  [2], n_u_cnt  [2];
    logic [SW-1:0] r_u_st   [2], n_u_st   [2];
    logic [TW-1:0] r_u_slot [2], n_u_slot [2];
    logic [W-1:0]  r_add_res, n_add_res;

    logic [7:0]    r_lat [4];

    logic          r_out_valid, r_out_issued, r_out_cv, r_out_idle;
    logic [3:0]    r_out_tag;
    logic [2:0]    r_out_reg;
    logic [31:0]   r_out_val;

    // tick temporaries
    logic          wb [2];
    logic [W-1:0]  wv;
    logic          disp [2];
    logic [SW-1:0] dsel [2];
    logic [1:0]    lidx;
    logic          is_op, is_mul, ffound;
    logic [SW-1:0] fsel;
    logic          s_imm [2];
    logic [2:0]    s_reg [2];
    logic [31:0]   s_val [2];
    logic [RW-1:0] ri, dest, cr;
    logic          t_issued, t_cv, t_idle;
    logic [3:0]    t_tag;
    logic [2:0]    t_reg;
    logic [31:0]   t_val;

    logic          mdu_start, mdu_div, mdu_done, mul_wait;
    logic [W-1:0]  mdu_a, mdu_b, mdu_res;

    assign q_in = '{op: i_op, dest_reg: i_dest_reg, src1_is_imm: i_src1_is_imm,
                    src1_reg: i_src1_reg, src1_imm: i_src1_imm,
                    src2_is_imm: i_src2_is_imm, src2_reg: i_src2_reg,
                    src2_imm: i_src2_imm};

    trs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && !q_full),
        .i_item  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (tick_fire)
    );

    trs_mdu #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mdu_start),
        .i_div   (mdu_div),
        .i_a     (mdu_a),
        .i_b     (mdu_b),
        .o_done  (mdu_done),
        .o_res   (mdu_res)
    );

    assign o_in_stall = q_full;
    assign mul_wait   = r_u_busy[U_MUL] && (r_u_cnt[U_MUL] == 9'd0) && !mdu_done;
    assign tick_fire  = q_valid && !(r_out_valid && i_out_stall) && !mul_wait;
    assign mdu_start  = tick_fire && disp[U_MUL];

    always_comb begin
        n_rf = r_rf; n_rn_v = r_rn_v; n_rn_tag = r_rn_tag;
        n_rn_done = r_rn_done; n_rn_val = r_rn_val;
        n_st_busy = r_st_busy; n_st_kind = r_st_kind; n_st_rdy = r_st_rdy;
        n_st_tag = r_st_tag; n_st_val = r_st_val; n_st_slot = r_st_slot;
        n_rob_done = r_rob_done; n_rob_reg = r_rob_reg; n_rob_val = r_rob_val;
        n_head = r_head; n_tail = r_tail; n_count = r_count;
        n_u_busy = r_u_busy; n_u_cnt = r_u_cnt; n_u_st = r_u_st; n_u_slot = r_u_slot;
        n_add_res = r_add_res;
        wv = '0; lidx = LAT_ADD; ri = '0; dest = '0; cr = '0;
        mdu_div = 1'b0; mdu_a = '0; mdu_b = '0;
        t_issued = 1'b0; t_cv = 1'b0; t_tag = '0; t_reg = '0; t_val = '0;
        s_imm[0] = q_item.src1_is_imm; s_reg[0] = q_item.src1_reg; s_val[0] = q_item.src1_imm;
        s_imm[1] = q_item.src2_is_imm; s_reg[1] = q_item.src2_reg; s_val[1] = q_item.src2_imm;

        // writeback and broadcast
        for (int u = 0; u < 2; u++) begin
            wb[u] = r_u_busy[u] && (r_u_cnt[u] == 9'd0);
            if (wb[u]) begin
                wv = (u == U_ADD) ? r_add_res : mdu_res;
                n_rob_done[r_u_slot[u]] = 1'b1;
                n_rob_val[r_u_slot[u]]  = wv;
                for (int i = 0; i < NS; i++) begin
                    for (int k = 0; k < 2; k++) begin
                        if (n_st_busy[i] && !n_st_rdy[i][k] && n_st_tag[i][k] == r_u_slot[u]) begin
                            n_st_rdy[i][k] = 1'b1;
                            n_st_val[i][k] = wv;
                        end
                    end
                end
                for (int r = 0; r < NUM_REGS; r++) begin
                    if (n_rn_v[r] && !n_rn_done[r] && n_rn_tag[r] == r_u_slot[u]) begin
                        n_rn_done[r] = 1'b1;
                        n_rn_val[r]  = wv;
                    end
                end
            end
        end

        // dispatch
        for (int u = 0; u < 2; u++) begin
            disp[u] = 1'b0;
            dsel[u] = '0;
            if (!r_u_busy[u]) begin
                for (int i = 0; i < NS; i++) begin
                    if (!disp[u] && ((u == U_ADD) == (i < ADD_STATIONS)) && n_st_busy[i]
                        && n_st_rdy[i][0] && n_st_rdy[i][1]) begin
                        disp[u] = 1'b1;
                        dsel[u] = SW'(i);
                    end
                end
            end
            if (disp[u]) begin
                if (u == U_ADD) begin
                    lidx      = n_st_kind[dsel[u]] ? LAT_SUB : LAT_ADD;
                    n_add_res = addsub(n_st_val[dsel[u]][0], n_st_val[dsel[u]][1],
                                       n_st_kind[dsel[u]]);
                end else begin
                    lidx    = n_st_kind[dsel[u]] ? LAT_DIV : LAT_MUL;
                    mdu_div = n_st_kind[dsel[u]];
                    mdu_a   = n_st_val[dsel[u]][0];
                    mdu_b   = n_st_val[dsel[u]][1];
                end
                n_u_busy[u] = 1'b1;
                n_u_cnt[u]  = 9'(r_lat[lidx]) + 9'd1;
                n_u_st[u]   = dsel[u];
                n_u_slot[u] = n_st_slot[dsel[u]];
            end
        end

        // issue
        unique case (q_item.op) inside
            OP_ADD, OP_SUB: begin
                is_op  = 1'b1;
                is_mul = 1'b0;
            end
            OP_MUL, OP_DIV: begin
                is_op  = 1'b1;
                is_mul = 1'b1;
            end
            default: begin
                is_op  = 1'b0;
                is_mul = 1'b0;
            end
        endcase
        ffound = 1'b0;
        fsel   = '0;
        for (int i = 0; i < NS; i++) begin
            if (!ffound && (is_mul == (i >= ADD_STATIONS)) && !n_st_busy[i]) begin
                ffound = 1'b1;
                fsel   = SW'(i);
            end
        end
        if (is_op && ffound && r_count < CW'(ROB_DEPTH)) begin
            for (int k = 0; k < 2; k++) begin
                n_st_tag[fsel][k] = '0;
                if (s_imm[k]) begin
                    n_st_rdy[fsel][k] = 1'b1;
                    n_st_val[fsel][k] = sat_w(64'($signed(s_val[k])));
                end else begin
                    ri = reg_idx(s_reg[k]);
                    if (n_rn_v[ri]) begin
                        if (n_rn_done[ri]) begin
                            n_st_rdy[fsel][k] = 1'b1;
                            n_st_val[fsel][k] = n_rn_val[ri];
                        end else begin
                            n_st_rdy[fsel][k] = 1'b0;
                            n_st_val[fsel][k] = '0;
                            n_st_tag[fsel][k] = n_rn_tag[ri];
                        end
                    end else begin
                        n_st_rdy[fsel][k] = 1'b1;
                        n_st_val[fsel][k] = n_rf[ri];
                    end
                end
            end
            dest                = reg_idx(q_item.dest_reg);
            n_st_busy[fsel]     = 1'b1;
            n_st_kind[fsel]     = (q_item.op == OP_SUB) || (q_item.op == OP_DIV);
            n_st_slot[fsel]     = r_tail;
            n_rob_done[r_tail]  = 1'b0;
            n_rob_reg[r_tail]   = dest;
            n_rob_val[r_tail]   = '0;
            n_rn_v[dest]        = 1'b1;
            n_rn_tag[dest]      = r_tail;
            n_rn_done[dest]     = 1'b0;
            n_tail   = (int'(r_tail) == ROB_DEPTH - 1) ? '0 : r_tail + 1'b1;
            n_count  = r_count + 1'b1;
            t_issued = 1'b1;
        end

        // commit
        if (n_count != '0 && n_rob_done[r_head]) begin
            cr = n_rob_reg[r_head];
            n_rf[cr] = n_rob_val[r_head];
            if (n_rn_v[cr] && n_rn_tag[cr] == r_head) begin
                n_rn_v[cr] = 1'b0;
            end
            t_cv  = 1'b1;
            t_tag = 4'(r_head);
            t_reg = 3'(cr);
            t_val = 32'($signed(n_rob_val[r_head]));
            n_rob_done[r_head] = 1'b0;
            n_head  = (int'(r_head) == ROB_DEPTH - 1) ? '0 : r_head + 1'b1;
            n_count = n_count - 1'b1;
        end

        // countdown and release
        for (int u = 0; u < 2; u++) begin
            if (n_u_cnt[u] != 9'd0) begin
                n_u_cnt[u] = n_u_cnt[u] - 9'd1;
            end
            if (wb[u]) begin
                n_st_busy[r_u_st[u]] = 1'b0;
                n_u_busy[u] = 1'b0;
            end
        end

        t_idle = (n_count == '0) && !n_u_busy[U_ADD] && !n_u_busy[U_MUL];
        for (int i = 0; i < NS; i++) begin
            if (n_st_busy[i]) begin
                t_idle = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_REGS; r++) begin
                r_rf[r]   <= (r < NUM_RESET_REGS) ? sat_w(RESET_REGS[r]) : '0;
                r_rn_v[r] <= 1'b0;
            end
            for (int i = 0; i < NS; i++) begin
                r_st_busy[i] <= 1'b0;
            end
            for (int u = 0; u < 2; u++) begin
                r_u_busy[u] <= 1'b0;
                r_u_cnt[u]  <= 9'd0;
            end
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_lat[LAT_ADD] <= ADD_LAT_DEF;
            r_lat[LAT_SUB] <= SUB_LAT_DEF;
            r_lat[LAT_MUL] <= MUL_LAT_DEF;
            r_lat[LAT_DIV] <= DIV_LAT_DEF;
        end else begin
            if (tick_fire) begin
                r_rf        <= n_rf;
                r_rn_v      <= n_rn_v;
                r_st_busy   <= n_st_busy;
                r_u_busy    <= n_u_busy;
                r_u_cnt     <= n_u_cnt;
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ADD_LAT: r_lat[LAT_ADD] <= i_cfg_wdata;
                    CFG_SUB_LAT: r_lat[LAT_SUB] <= i_cfg_wdata;
                    CFG_MUL_LAT: r_lat[LAT_MUL] <= i_cfg_wdata;
                    CFG_DIV_LAT: r_lat[LAT_DIV] <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_fire) begin
            r_rn_tag     <= n_rn_tag;
            r_rn_done    <= n_rn_done;
            r_rn_val     <= n_rn_val;
            r_st_kind    <= n_st_kind;
            r_st_rdy     <= n_st_rdy;
            r_st_tag     <= n_st_tag;
            r_st_val     <= n_st_val;
            r_st_slot    <= n_st_slot;
            r_rob_done   <= n_rob_done;
            r_rob_reg    <= n_rob_reg;
            r_rob_val    <= n_rob_val;
            r_u_st       <= n_u_st;
            r_u_slot     <= n_u_slot;
            r_add_res    <= n_add_res;
            r_out_issued <= t_issued;
            r_out_cv     <= t_cv;
            r_out_tag    <= t_tag;
            r_out_reg    <= t_reg;
            r_out_val    <= t_val;
            r_out_idle   <= t_idle;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_issued       = r_out_issued;
    assign o_commit_valid = r_out_cv;
    assign o_commit_tag   = r_out_tag;
    assign o_commit_reg   = r_out_reg;
    assign o_commit_value = r_out_val;
    assign o_idle         = r_out_idle;

endmodule

@@ rtl/core/tomasulo_rob_scheduler_core_chk.sv @@
`include "tomasulo_rob_scheduler_core_assert.svh"

module tomasulo_rob_scheduler_core_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_issued,
    input logic               o_commit_valid,
    input logic [3:0]         o_commit_tag,
    input logic [2:0]         o_commit_reg,
    input logic signed [31:0] o_commit_value,
    input logic               o_idle
);

    `TRS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_commit_value) && $stable(o_commit_tag))
    `TRS_ASSERT_SAME(a_no_commit_zero, o_out_valid && !o_commit_valid, o_commit_tag == 4'd0 && o_commit_reg == 3'd0 && o_commit_value == 32'sd0)
    `TRS_ASSERT_SAME(a_idle_no_issue, o_out_valid && o_idle, !o_issued)

endmodule

bind tomasulo_rob_scheduler_core tomasulo_rob_scheduler_core_chk u_chk (.*);

@@ verif/tb_tomasulo_rob_scheduler_core.sv @@
`timescale 1ns / 1ps

module tb_tomasulo_rob_scheduler_core;
    import trs_pkg::*;

    localparam int NREG = 8;
    localparam int NADD = 3;
    localparam int NMUL = 2;
    localparam int NROB = 16;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    typedef struct {
        logic [2:0]  op;
        logic [2:0]  dest_reg;
        logic        src1_is_imm;
        logic [2:0]  src1_reg;
        logic [31:0] src1_imm;
        logic        src2_is_imm;
        logic [2:0]  src2_reg;
        logic [31:0] src2_imm;
    } tick_t;

    typedef struct {
        logic        issued;
        logic        commit_valid;
        logic [3:0]  commit_tag;
        logic [2:0]  commit_reg;
        logic [31:0] commit_value;
        logic        idle;
    } tick_result_t;

    typedef struct {
        bit          busy;
        bit          kind;
        bit          rdy [2];
        logic [3:0]  tag [2];
        longint      val [2];
        logic [3:0]  slot;
    } rs_entry_t;

    typedef struct {
        bit      busy;
        bit      wrote;
        int      count;
        int      st;
        logic [3:0] slot;
        longint  res;
    } fu_t;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_stall;
    logic [2:0] i_op = 0;
    logic [2:0] i_dest_reg = 0;
    logic i_src1_is_imm = 0;
    logic [2:0] i_src1_reg = 0;
    logic signed [31:0] i_src1_imm = 0;
    logic i_src2_is_imm = 0;
    logic [2:0] i_src2_reg = 0;
    logic signed [31:0] i_src2_imm = 0;
    logic o_out_valid;
    logic i_out_stall = 1;
    logic o_issued, o_commit_valid, o_idle;
    logic [3:0] o_commit_tag;
    logic [2:0] o_commit_reg;
    logic signed [31:0] o_commit_value;
    logic i_cfg_we = 0;
    logic [2:0] i_cfg_index = 0;
    logic [7:0] i_cfg_wdata = 0;

    tomasulo_rob_scheduler_core dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    longint    regs [NREG];
    bit        ren_valid [NREG];
    logic [3:0] ren_tag [NREG];
    rs_entry_t add_rs [NADD];
    rs_entry_t mul_rs [NMUL];
    bit        rob_done [NROB];
    logic [2:0] rob_reg [NROB];
    longint    rob_val [NROB];
    int        rob_head, rob_count;
    fu_t       add_fu, mul_fu;
    int        lat_add, lat_sub, lat_mul, lat_div;

    tick_t        pending_ticks [$];
    tick_result_t expected_results [$];
    int  errors = 0;
    int  n_sent = 0, n_recv = 0, n_commits = 0, n_issued = 0;
    bit  stim_done = 0;
    bit  hold_out = 0;
    int  idle_cycles = 0;

    function automatic longint sat(longint x);
        if (x > VMAX) return VMAX;
        if (x < VMIN) return VMIN;
        return x;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic signed [127:0] p;
        logic [127:0] m;
        bit neg;
        neg = (a < 0) != (b < 0);
        p = 128'(a) * 128'(b);
        m = p < 0 ? -p : p;
        m = m >> 16;
        if (!neg) return m > 128'(VMAX) ? VMAX : longint'(m);
        return m > 128'(64'd2147483648) ? VMIN : -longint'(m);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        logic [127:0] ma, mb, q;
        bit neg;
        if (b == 0) return a > 0 ? VMAX : (a < 0 ? VMIN : 0);
        ma = a < 0 ? 128'(-a) : 128'(a);
        mb = b < 0 ? 128'(-b) : 128'(b);
        q = (ma << 16) / mb;
        neg = (a < 0) != (b < 0);
        if (!neg) return q > 128'(VMAX) ? VMAX : longint'(q);
        return q > 128'(64'd2147483648) ? VMIN : -longint'(q);
    endfunction

    function automatic void add_tick(tick_t t);
        pending_ticks = {pending_ticks, t};
    endfunction

    function automatic void writeback_fu(inout fu_t u);
        if (u.busy && !u.wrote && u.count == 0) begin
            rob_val[u.slot] = u.res;
            rob_done[u.slot] = 1;
            for (int i = 0; i < NADD; i++)
                for (int k = 0; k < 2; k++)
                    if (add_rs[i].busy && !add_rs[i].rdy[k] && add_rs[i].tag[k] == u.slot) begin
                        add_rs[i].rdy[k] = 1;
                        add_rs[i].val[k] = u.res;
                    end
            for (int i = 0; i < NMUL; i++)
                for (int k = 0; k < 2; k++)
                    if (mul_rs[i].busy && !mul_rs[i].rdy[k] && mul_rs[i].tag[k] == u.slot) begin
                        mul_rs[i].rdy[k] = 1;
                        mul_rs[i].val[k] = u.res;
                    end
            u.wrote = 1;
        end
    endfunction

    function automatic longint operand(logic is_imm, logic [2:0] r, logic [31:0] imm,
                                       output bit rdy, output logic [3:0] tag);
        tag = 0;
        rdy = 1;
        if (is_imm) return longint'(signed'(imm));
        if (ren_valid[r]) begin
            if (rob_done[ren_tag[r]]) return rob_val[ren_tag[r]];
            rdy = 0;
            tag = ren_tag[r];
            return 0;
        end
        return regs[r];
    endfunction

    function automatic tick_result_t predict_tick(tick_t t);
        tick_result_t res;
        int f, tl;
        bit is_mul;
        res = '{default: 0};
        writeback_fu(add_fu);
        writeback_fu(mul_fu);
        if (!add_fu.busy) begin
            for (int i = 0; i < NADD; i++) begin
                if (add_rs[i].busy && add_rs[i].rdy[0] && add_rs[i].rdy[1]) begin
                    longint a, b;
                    a = add_rs[i].val[0];
                    b = add_rs[i].val[1];
                    add_fu.res = sat(add_rs[i].kind ? a - b : a + b);
                    add_fu.count = (add_rs[i].kind ? lat_sub : lat_add) + 1;
                    add_fu.busy = 1; add_fu.wrote = 0; add_fu.st = i;
                    add_fu.slot = add_rs[i].slot;
                    break;
                end
            end
        end
        if (!mul_fu.busy) begin
            for (int i = 0; i < NMUL; i++) begin
                if (mul_rs[i].busy && mul_rs[i].rdy[0] && mul_rs[i].rdy[1]) begin
                    longint a, b;
                    a = mul_rs[i].val[0];
                    b = mul_rs[i].val[1];
                    mul_fu.res = mul_rs[i].kind ? fx_div(a, b) : fx_mul(a, b);
                    mul_fu.count = (mul_rs[i].kind ? lat_div : lat_mul) + 1;
                    mul_fu.busy = 1; mul_fu.wrote = 0; mul_fu.st = i;
                    mul_fu.slot = mul_rs[i].slot;
                    break;
                end
            end
        end
        if (t.op >= OP_ADD && t.op <= OP_DIV) begin
            rs_entry_t e;
            is_mul = t.op >= OP_MUL;
            f = -1;
            for (int i = 0; i < (is_mul ? NMUL : NADD); i++)
                if (!(is_mul ? mul_rs[i].busy : add_rs[i].busy)) begin
                    f = i;
                    break;
                end
            if (f >= 0 && rob_count < NROB) begin
                tl = (rob_head + rob_count) % NROB;
                e.val[0] = operand(t.src1_is_imm, t.src1_reg, t.src1_imm, e.rdy[0], e.tag[0]);
                e.val[1] = operand(t.src2_is_imm, t.src2_reg, t.src2_imm, e.rdy[1], e.tag[1]);
                e.busy = 1;
                e.kind = is_mul ? (t.op == OP_DIV) : (t.op == OP_SUB);
                e.slot = 4'(tl);
                if (is_mul) mul_rs[f] = e;
                else add_rs[f] = e;
                rob_done[tl] = 0;
                rob_reg[tl] = t.dest_reg;
                rob_val[tl] = 0;
                ren_valid[t.dest_reg] = 1;
                ren_tag[t.dest_reg] = 4'(tl);
                rob_count++;
                res.issued = 1;
            end
        end
        if (rob_count > 0 && rob_done[rob_head]) begin
            logic [2:0] r;
            r = rob_reg[rob_head];
            regs[r] = rob_val[rob_head];
            if (ren_valid[r] && ren_tag[r] == rob_head) ren_valid[r] = 0;
            res.commit_valid = 1;
            res.commit_tag = 4'(rob_head);
            res.commit_reg = r;
            res.commit_value = rob_val[rob_head][31:0];
            rob_done[rob_head] = 0;
            rob_head = (rob_head + 1) % NROB;
            rob_count--;
        end
        if (add_fu.count > 0) add_fu.count--;
        if (add_fu.busy && add_fu.wrote) begin
            add_rs[add_fu.st].busy = 0;
            add_fu.busy = 0; add_fu.wrote = 0;
        end
        if (mul_fu.count > 0) mul_fu.count--;
        if (mul_fu.busy && mul_fu.wrote) begin
            mul_rs[mul_fu.st].busy = 0;
            mul_fu.busy = 0; mul_fu.wrote = 0;
        end
        res.idle = rob_count == 0 && !add_fu.busy && !mul_fu.busy;
        for (int i = 0; i < NADD; i++) if (add_rs[i].busy) res.idle = 0;
        for (int i = 0; i < NMUL; i++) if (mul_rs[i].busy) res.idle = 0;
        return res;
    endfunction

    task automatic reset_model();
        for (int i = 0; i < NREG; i++) begin
            regs[i] = i < NUM_RESET_REGS ? RESET_REGS[i] : 0;
            ren_valid[i] = 0;
            ren_tag[i] = 0;
        end
        foreach (add_rs[i]) add_rs[i] = '{default: 0};
        foreach (mul_rs[i]) mul_rs[i] = '{default: 0};
        for (int i = 0; i < NROB; i++) begin
            rob_done[i] = 0; rob_reg[i] = 0; rob_val[i] = 0;
        end
        rob_head = 0; rob_count = 0;
        add_fu = '{default: 0};
        mul_fu = '{default: 0};
        lat_add = ADD_LAT_DEF; lat_sub = SUB_LAT_DEF;
        lat_mul = MUL_LAT_DEF; lat_div = DIV_LAT_DEF;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_imm();
        case ($urandom_range(0, 6))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 0;
            3: return $urandom_range(0, 8) << 16;
            4: return -($urandom_range(0, 8) << 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        int r;
        r = $urandom_range(0, 99);
        t.op = r < 10 ? OP_TICK : (r < 14 ? 3'($urandom_range(5, 7)) :
               3'($urandom_range(OP_ADD, OP_DIV)));
        t.dest_reg = 3'($urandom);
        t.src1_is_imm = 1'($urandom);
        t.src1_reg = 3'($urandom);
        t.src1_imm = rand_imm();
        t.src2_is_imm = 1'($urandom);
        t.src2_reg = 3'($urandom);
        t.src2_imm = rand_imm();
        return t;
    endfunction

    function automatic tick_t mk(logic [2:0] op, logic [2:0] d, logic i1, logic [2:0] r1,
                                 logic [31:0] m1, logic i2, logic [2:0] r2, logic [31:0] m2);
        tick_t t;
        t.op = op; t.dest_reg = d;
        t.src1_is_imm = i1; t.src1_reg = r1; t.src1_imm = m1;
        t.src2_is_imm = i2; t.src2_reg = r2; t.src2_imm = m2;
        return t;
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                n_sent++;
                expected_results = {expected_results, predict_tick(pending_ticks.pop_front())};
                send_gap = gap_len();
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0 || pending_ticks.size() == 0) begin
                    i_in_valid <= 0;
                    if (send_gap > 0) send_gap--;
                end else begin
                    i_in_valid <= 1;
                    i_op <= pending_ticks[0].op;
                    i_dest_reg <= pending_ticks[0].dest_reg;
                    i_src1_is_imm <= pending_ticks[0].src1_is_imm;
                    i_src1_reg <= pending_ticks[0].src1_reg;
                    i_src1_imm <= pending_ticks[0].src1_imm;
                    i_src2_is_imm <= pending_ticks[0].src2_is_imm;
                    i_src2_reg <= pending_ticks[0].src2_reg;
                    i_src2_imm <= pending_ticks[0].src2_imm;
                end
            end
        end
    end

    // monitor
    int recv_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                tick_result_t e;
                n_recv++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result item", $time);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_commit_valid) n_commits++;
                    if (o_issued) n_issued++;
                    if ({o_issued, o_commit_valid, o_commit_tag, o_commit_reg, o_commit_value,
                         o_idle} !== {e.issued, e.commit_valid, e.commit_tag, e.commit_reg,
                         e.commit_value, e.idle}) begin
                        $display("%0t: mismatch exp issued=%0b cv=%0b tag=%0d reg=%0d val=%h idle=%0b",
                                 $time, e.issued, e.commit_valid, e.commit_tag, e.commit_reg,
                                 e.commit_value, e.idle);
                        $display("%0t:          act issued=%0b cv=%0b tag=%0d reg=%0d val=%h idle=%0b",
                                 $time, o_issued, o_commit_valid, o_commit_tag, o_commit_reg,
                                 o_commit_value, o_idle);
                        errors++;
                    end
                end
                recv_gap = gap_len();
            end
            if (hold_out) i_out_stall <= 1;
            else if (recv_gap > 0) begin
                i_out_stall <= 1;
                recv_gap--;
            end else i_out_stall <= 0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else if (!hold_out) idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_latency(logic [2:0] idx, logic [7:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_ADD_LAT: lat_add = v;
            CFG_SUB_LAT: lat_sub = v;
            CFG_MUL_LAT: lat_mul = v;
            default:     lat_div = v;
        endcase
    endtask

    task automatic drain();
        wait (pending_ticks.size() == 0 && expected_results.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_phase(int n);
        for (int i = 0; i < n; i++) begin
            // mostly dependent chains through a few registers
            tick_t t;
            t = rand_tick();
            if ($urandom_range(0, 3) != 0) begin
                t.src1_reg = 3'($urandom_range(0, 3));
                t.src2_reg = 3'($urandom_range(0, 3));
                t.dest_reg = 3'($urandom_range(0, 3));
            end
            add_tick(t);
        end
        drain();
    endtask

    initial begin
        reset_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        // directed
        add_tick(mk(OP_ADD, 6, 0, 2, 0, 0, 3, 0));
        add_tick(mk(OP_SUB, 7, 0, 6, 0, 0, 5, 0));
        add_tick(mk(OP_MUL, 1, 0, 7, 0, 0, 4, 0));
        add_tick(mk(OP_DIV, 2, 0, 1, 0, 0, 3, 0));
        add_tick(mk(OP_DIV, 3, 1, 0, 32'h00010000, 1, 0, 0));
        add_tick(mk(OP_DIV, 4, 1, 0, 32'h80000000, 1, 0, 0));
        add_tick(mk(OP_DIV, 5, 1, 0, 0, 1, 0, 0));
        add_tick(mk(OP_ADD, 0, 1, 0, 32'h7fffffff, 1, 0, 32'h7fffffff));
        add_tick(mk(OP_SUB, 0, 1, 0, 32'h80000000, 1, 0, 32'h7fffffff));
        add_tick(mk(OP_MUL, 1, 1, 0, 32'h80000000, 1, 0, 32'h80000000));
        add_tick(mk(OP_MUL, 1, 1, 7, 32'hffffffff, 1, 7, 32'h00000001));
        add_tick(mk(OP_DIV, 2, 1, 7, 32'h7fffffff, 1, 7, 32'hffffffff));
        add_tick(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        add_tick(mk(3'd7, 7, 1, 7, 32'hffffffff, 1, 7, 32'hffffffff));
        for (int i = 0; i < 6; i++) add_tick(mk(OP_ADD, 7, 0, 7, 0, 1, 0, 1));
        for (int i = 0; i < 4; i++) add_tick(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        drain();
        write_latency(CFG_ADD_LAT, 1); write_latency(CFG_SUB_LAT, 1);
        write_latency(CFG_MUL_LAT, 1); write_latency(CFG_DIV_LAT, 1);
        run_phase(350);
        write_latency(CFG_ADD_LAT, 255); write_latency(CFG_SUB_LAT, 7);
        write_latency(CFG_MUL_LAT, 3); write_latency(CFG_DIV_LAT, 255);
        run_phase(150);
        write_latency(CFG_ADD_LAT, 2); write_latency(CFG_SUB_LAT, 255);
        write_latency(CFG_MUL_LAT, 255); write_latency(CFG_DIV_LAT, 5);
        run_phase(150);
        write_latency(CFG_ADD_LAT, 8'($urandom_range(1, 9)));
        write_latency(CFG_SUB_LAT, 8'($urandom_range(1, 9)));
        write_latency(CFG_MUL_LAT, 8'($urandom_range(1, 20)));
        write_latency(CFG_DIV_LAT, 8'($urandom_range(1, 50)));
        // hold the receiver off while ticks keep coming
        hold_out = 1;
        for (int i = 0; i < 600; i++) add_tick(rand_tick());
        repeat (300) @(posedge i_clk);
        hold_out = 0;
        drain();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        repeat (50) @(posedge i_clk);
        $display("Covered %0d ticks, %0d issued, %0d commits over five latency settings.",
                 n_sent, n_issued, n_commits);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
